// File: sv/rled_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rled_pkg
// Shared constants for the run-length encoder with delta coding.
// ----------------------------------------------------------------------------
package rled_pkg;

	// Configuration register map: word index taken from paddr[PADDR_BITS-1:2]
	localparam int unsigned PADDR_BITS   = 3;
	localparam int unsigned PDATA_BITS   = 32;
	localparam bit          REG_DELTA_MODE = 1'b0;

	// Result queue geometry
	localparam int unsigned FIFO_DEPTH    = 4;
	localparam int unsigned FIFO_PTR_BITS = 2;
	localparam int unsigned FIFO_CNT_BITS = 3;

	// Accept a new item only while this many slots or fewer are in use
	localparam logic [FIFO_CNT_BITS-1:0] FIFO_ROOM_LIMIT = 3'd2;

endpackage

// File: sv/run_length_encoder_with_delta.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// run_length_encoder_with_delta
// Run-length encoder for a symbol stream, with optional delta coding of the
// run symbols.
//
// The block takes one symbol per clock cycle while in_stall is low. Each
// transfer is captured in an input register; when the queue has room, short
// logic merges it into the open run and writes zero, one or two (symbol_out,
// run_length, last_run) pairs into a four-entry result queue, which drives
// the output channel.
// A run closes when the symbol changes or when its count would pass
// 2^RUN_BITS-1; a symbol flagged with last_in also closes its own run, so it
// can produce two pairs in one cycle. The queue drains one pair per cycle
// while out_stall is low, and in_stall rises while three or more pairs are
// queued, since the held item could add two. A two-pair flush ends the
// stream, so the item after it adds at most one pair: with a free-flowing
// output the queue never holds over two pairs and the input takes one symbol
// every cycle. Input stalls come only from out_stall backing up the queue.
// In delta mode (register 0, bit 0, at byte address 0) the first pair of a
// stream is raw, later pairs carry the run symbol minus the previous run
// symbol, and a pair that follows a negative value is raw again. Write the
// mode only while the block is idle.
// ----------------------------------------------------------------------------
module run_length_encoder_with_delta #(
	parameter int unsigned SYMBOL_BITS = 16,
	parameter int unsigned RUN_BITS    = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,

	// Configuration port
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [rled_pkg::PADDR_BITS-1:0]        paddr,
	input  logic [rled_pkg::PDATA_BITS-1:0]        pwdata,
	output logic [rled_pkg::PDATA_BITS-1:0]        prdata,
	output logic                                   pready,

	// Symbol input channel
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [SYMBOL_BITS-1:0]                 symbol,
	input  logic                                   last_in,

	// Run pair output channel
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [SYMBOL_BITS:0]            symbol_out,
	output logic [RUN_BITS-1:0]                    run_length,
	output logic                                   last_run
);

	localparam int unsigned DEPTH = rled_pkg::FIFO_DEPTH;
	localparam int unsigned PB    = rled_pkg::FIFO_PTR_BITS;
	localparam int unsigned CB    = rled_pkg::FIFO_CNT_BITS;

	// ------------------------------------------------------------------
	// Configuration register
	// ------------------------------------------------------------------
	logic delta_mode_q;
	logic cfg_write;
	logic cfg_hit;

	assign pready    = 1'b1;
	assign cfg_hit   = (paddr[rled_pkg::PADDR_BITS-1] == rled_pkg::REG_DELTA_MODE);
	assign cfg_write = psel && penable && pwrite && pready && cfg_hit;
	assign prdata    = cfg_hit ? {{(rled_pkg::PDATA_BITS-1){1'b0}}, delta_mode_q}
	                           : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delta_mode_q <= 1'b0;
		end else if (cfg_write) begin
			delta_mode_q <= pwdata[0];
		end
	end

	// ------------------------------------------------------------------
	// Input register
	// ------------------------------------------------------------------
	logic                   valid_s1;
	logic [SYMBOL_BITS-1:0] symbol_s1;
	logic                   last_s1;
	logic                   room;
	logic                   go;
	logic                   in_xfer;

	logic [CB-1:0]          fifo_cnt_q;

	// Consume the held item only when the queue can take two pairs
	assign room     = (fifo_cnt_q <= rled_pkg::FIFO_ROOM_LIMIT);
	assign go       = valid_s1 && room;
	assign in_stall = valid_s1 && !room;
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			symbol_s1 <= symbol;
			last_s1   <= last_in;
		end
	end

	// ------------------------------------------------------------------
	// Run state and pair generation
	// ------------------------------------------------------------------
	logic [SYMBOL_BITS-1:0] run_symbol_q;
	logic [RUN_BITS-1:0]    run_count_q;
	logic                   run_open_q;
	logic [SYMBOL_BITS-1:0] prior_symbol_q;
	logic                   first_pair_q;
	logic                   prior_neg_q;

	// Coded value of a closing run: raw or difference to the previous run
	function automatic logic signed [SYMBOL_BITS:0] code_value(
		input logic                   use_delta,
		input logic [SYMBOL_BITS-1:0] cur,
		input logic [SYMBOL_BITS-1:0] prev
	);
		logic signed [SYMBOL_BITS:0] res;
		if (use_delta) begin
			res = $signed({1'b0, cur}) - $signed({1'b0, prev});
		end else begin
			res = $signed({1'b0, cur});
		end
		return res;
	endfunction

	logic                        close_run;
	logic                        same_sym;
	logic                        count_full;
	logic signed [SYMBOL_BITS:0] val_a;
	logic                        neg_a;
	logic [SYMBOL_BITS-1:0]      prior_mid;
	logic                        first_mid;
	logic                        neg_mid;
	logic [SYMBOL_BITS-1:0]      next_symbol;
	logic [RUN_BITS-1:0]         next_count;
	logic signed [SYMBOL_BITS:0] val_b;

	always_comb begin
		same_sym   = (symbol_s1 == run_symbol_q);
		count_full = (run_count_q == {RUN_BITS{1'b1}});
		close_run  = run_open_q && !(same_sym && !count_full);

		// Pair for the run that this symbol closes
		val_a = code_value(delta_mode_q && !first_pair_q && !prior_neg_q,
		                   run_symbol_q, prior_symbol_q);
		neg_a = val_a[SYMBOL_BITS];

		// Delta chain as seen after that pair
		prior_mid = close_run ? run_symbol_q : prior_symbol_q;
		first_mid = close_run ? 1'b0 : first_pair_q;
		neg_mid   = close_run ? neg_a : prior_neg_q;

		// Extend the open run or start a new one
		if (!run_open_q || close_run) begin
			next_symbol = symbol_s1;
			next_count  = {{(RUN_BITS-1){1'b0}}, 1'b1};
		end else begin
			next_symbol = run_symbol_q;
			next_count  = run_count_q + {{(RUN_BITS-1){1'b0}}, 1'b1};
		end

		// Pair for the run that a last symbol ends
		val_b = code_value(delta_mode_q && !first_mid && !neg_mid,
		                   next_symbol, prior_mid);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_symbol_q   <= '0;
			run_count_q    <= '0;
			run_open_q     <= 1'b0;
			prior_symbol_q <= '0;
			first_pair_q   <= 1'b1;
			prior_neg_q    <= 1'b0;
		end else if (go) begin
			run_symbol_q <= next_symbol;
			if (last_s1) begin
				// Close the stream and restart the delta chain
				run_count_q    <= '0;
				run_open_q     <= 1'b0;
				prior_symbol_q <= next_symbol;
				first_pair_q   <= 1'b1;
				prior_neg_q    <= 1'b0;
			end else begin
				run_count_q    <= next_count;
				run_open_q     <= 1'b1;
				prior_symbol_q <= prior_mid;
				first_pair_q   <= first_mid;
				prior_neg_q    <= neg_mid;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result queue
	// ------------------------------------------------------------------
	logic signed [SYMBOL_BITS:0] fifo_sym_q  [DEPTH];
	logic [RUN_BITS-1:0]         fifo_len_q  [DEPTH];
	logic                        fifo_last_q [DEPTH];
	logic [PB-1:0]               wr_ptr_q;
	logic [PB-1:0]               rd_ptr_q;
	logic                        push_a;
	logic                        push_b;
	logic [1:0]                  push_n;
	logic                        pop;
	logic [PB-1:0]               wr_ptr_b;

	assign push_a   = go && close_run;
	assign push_b   = go && last_s1;
	assign push_n   = {1'b0, push_a} + {1'b0, push_b};
	assign out_valid = (fifo_cnt_q != '0);
	assign pop      = out_valid && !out_stall;
	assign wr_ptr_b = push_a ? (wr_ptr_q + {{(PB-1){1'b0}}, 1'b1}) : wr_ptr_q;

	always_ff @(posedge clk) begin
		if (push_a) begin
			fifo_sym_q[wr_ptr_q]  <= val_a;
			fifo_len_q[wr_ptr_q]  <= run_count_q;
			fifo_last_q[wr_ptr_q] <= 1'b0;
		end
		if (push_b) begin
			fifo_sym_q[wr_ptr_b]  <= val_b;
			fifo_len_q[wr_ptr_b]  <= next_count;
			fifo_last_q[wr_ptr_b] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
		end else begin
			wr_ptr_q   <= wr_ptr_q + PB'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + {{(PB-1){1'b0}}, 1'b1};
			end
			fifo_cnt_q <= fifo_cnt_q + CB'(push_n) - CB'(pop);
		end
	end

	assign symbol_out = fifo_sym_q[rd_ptr_q];
	assign run_length = fifo_len_q[rd_ptr_q];
	assign last_run   = fifo_last_q[rd_ptr_q];

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_cnt_q <= CB'(DEPTH))
		else $error("result queue overfilled");

	a_open_count: assert property (@(posedge clk) disable iff (!arst_n)
		run_open_q |-> (run_count_q != '0))
		else $error("open run with zero count");

	a_closed_first: assert property (@(posedge clk) disable iff (!arst_n)
		!run_open_q |-> first_pair_q)
		else $error("delta chain not restarted while no run is open");

	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(go && last_s1) |=> (!run_open_q && (fifo_cnt_q != '0)))
		else $error("last symbol did not close the stream");

endmodule

// File: test/run_length_encoder_with_delta_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// run_length_encoder_with_delta_tb
// Self-checking bench for the run-length encoder with delta coding.
//
// Symbols go in over the valid/stall channel. A run tracker in the bench
// mirrors the open run, the delta chain and the mode register, and queues
// the (symbol_out, run_length, last_run) pairs that each transfer must
// produce. A monitor pops the oldest pair on every output transfer and
// compares it field by field. Directed streams cover raw and delta coding,
// the widest positive and negative deltas and a mode change inside an open
// stream. Random streams follow, with idle bursts on both channels, and a
// final stretch runs at full rate.
// ----------------------------------------------------------------------------
module run_length_encoder_with_delta_tb;

	localparam int unsigned SYM_W   = 16;
	localparam int unsigned RUN_W   = 16;
	localparam int unsigned ADDR_W  = rled_pkg::PADDR_BITS;
	localparam int unsigned DATA_W  = rled_pkg::PDATA_BITS;
	localparam logic [RUN_W-1:0] COUNT_MAX = '1;
	localparam logic [SYM_W-1:0] SYM_MAX   = '1;
	localparam logic [ADDR_W-1:0] DELTA_MODE_ADDR = {rled_pkg::REG_DELTA_MODE, 2'b00};
	// Settle time for the input register plus result queue, padded for safety
	localparam int unsigned DRAIN_CYCLES = 4;

	typedef struct {
		logic signed [SYM_W:0] sym;
		logic [RUN_W-1:0]      len;
		logic                  last;
	} run_pair_t;

	// DUT ports
	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   psel = 1'b0;
	logic                   penable = 1'b0;
	logic                   pwrite = 1'b0;
	logic [ADDR_W-1:0]      paddr = '0;
	logic [DATA_W-1:0]      pwdata = '0;
	logic [DATA_W-1:0]      prdata;
	logic                   pready;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic [SYM_W-1:0]       symbol = '0;
	logic                   last_in = 1'b0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic signed [SYM_W:0]  symbol_out;
	logic [RUN_W-1:0]       run_length;
	logic                   last_run;

	// Run tracker state
	logic [SYM_W-1:0]       trk_run_sym;
	logic [RUN_W-1:0]       trk_run_cnt;
	bit                     trk_run_open;
	logic [SYM_W-1:0]       trk_prior_sym;
	bit                     trk_first_pending;
	bit                     trk_prior_neg;
	bit                     trk_delta_on;

	run_pair_t              pending_pairs[$];

	bit                     idle_on = 1'b0;
	int unsigned            out_hold_left = 0;
	int unsigned            mismatches = 0;
	int unsigned            symbols_sent = 0;
	int unsigned            pairs_seen = 0;
	int unsigned            count_splits = 0;
	int unsigned            negative_deltas = 0;
	int unsigned            delta_pairs = 0;

	run_length_encoder_with_delta #(
		.SYMBOL_BITS(SYM_W),
		.RUN_BITS(RUN_W)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.symbol(symbol),
		.last_in(last_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.symbol_out(symbol_out),
		.run_length(run_length),
		.last_run(last_run)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Run tracker
	// ------------------------------------------------------------------

	task automatic tracker_reset();
		trk_run_sym       = '0;
		trk_run_cnt       = '0;
		trk_run_open      = 1'b0;
		trk_prior_sym     = '0;
		trk_first_pending = 1'b1;
		trk_prior_neg     = 1'b0;
		trk_delta_on      = 1'b0;
	endtask

	// Close the open run: code its symbol and queue the pair
	task automatic close_run(input bit is_last);
		int        coded;
		run_pair_t pair;
		if (trk_delta_on && !trk_first_pending && !trk_prior_neg) begin
			coded = int'(trk_run_sym) - int'(trk_prior_sym);
			delta_pairs++;
		end else begin
			coded = int'(trk_run_sym);
		end
		if (coded < 0)
			negative_deltas++;
		pair.sym  = coded[SYM_W:0];
		pair.len  = trk_run_cnt;
		pair.last = is_last;
		pending_pairs = {pending_pairs, pair};
		trk_prior_neg     = (coded < 0);
		trk_prior_sym     = trk_run_sym;
		trk_first_pending = 1'b0;
	endtask

	// Fold one accepted symbol into the run and queue whatever it closes
	task automatic track_symbol(input logic [SYM_W-1:0] sym, input bit is_last);
		if (!trk_run_open) begin
			trk_run_sym  = sym;
			trk_run_cnt  = RUN_W'(1);
			trk_run_open = 1'b1;
		end else if (sym == trk_run_sym && trk_run_cnt != COUNT_MAX) begin
			trk_run_cnt++;
		end else begin
			if (sym == trk_run_sym)
				count_splits++;
			close_run(1'b0);
			trk_run_sym = sym;
			trk_run_cnt = RUN_W'(1);
		end
		if (is_last) begin
			close_run(1'b1);
			trk_run_open      = 1'b0;
			trk_run_cnt       = '0;
			trk_first_pending = 1'b1;
			trk_prior_neg     = 1'b0;
		end
	endtask

	// ------------------------------------------------------------------
	// Output side: random stall bursts and the pair monitor
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		if (out_hold_left == 0 && idle_on && $urandom_range(0, 5) == 0)
			out_hold_left = $urandom_range(1, 5);
		if (out_hold_left != 0) begin
			out_stall <= 1'b1;
			out_hold_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic check_pair();
		run_pair_t want;
		pairs_seen++;
		if (pending_pairs.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: unexpected pair sym=%0d len=%0d last=%0b",
					$realtime, symbol_out, run_length, last_run);
			return;
		end
		want = pending_pairs.pop_front();
		if (symbol_out !== want.sym || run_length !== want.len || last_run !== want.last) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: pair %0d exp sym=%0d len=%0d last=%0b, got sym=%0d len=%0d last=%0b",
					$realtime, pairs_seen, want.sym, want.len, want.last,
					symbol_out, run_length, last_run);
		end
	endtask

	// Sample pre-edge values: a transfer happens when valid is high and stall low
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0)
			check_pair();
	end

	// ------------------------------------------------------------------
	// Drivers; every task starts and ends just after a rising edge
	// ------------------------------------------------------------------

	// Hold the symbol until it transfers, then maybe leave a gap
	task automatic send_symbol(input logic [SYM_W-1:0] sym, input bit is_last);
		in_valid <= 1'b1;
		symbol   <= sym;
		last_in  <= is_last;
		do @(posedge clk); while (in_stall !== 1'b0);
		track_symbol(sym, is_last);
		symbols_sent++;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	// Drop valid, wait for every queued pair, then let the pipeline settle
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_pairs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write the mode through setup and access phases, then read it back
	task automatic set_delta_mode(input bit mode);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= DELTA_MODE_ADDR;
		pwdata  <= DATA_W'(mode);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		trk_delta_on = mode;
		// Go straight into the read setup phase
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (prdata !== DATA_W'(mode)) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: delta_mode readback exp %0h got %0h",
					$realtime, DATA_W'(mode), prdata);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Raw coding: field extremes, alternating bit patterns, a one-symbol stream
	task automatic test_raw_runs();
		set_delta_mode(1'b0);
		send_symbol('0, 1'b0);
		send_symbol('0, 1'b0);
		send_symbol(SYM_MAX, 1'b0);
		send_symbol(SYM_MAX, 1'b0);
		send_symbol(16'hAAAA, 1'b0);
		send_symbol(16'h5555, 1'b1);
		send_symbol(16'h1234, 1'b1);
		drain();
	endtask

	// Delta chain: widest positive and negative deltas, raw after a negative,
	// and a restart of the chain after the end of a stream
	task automatic test_delta_chain();
		set_delta_mode(1'b1);
		send_symbol('0, 1'b0);
		send_symbol(SYM_MAX, 1'b0);
		send_symbol('0, 1'b0);
		send_symbol(16'd7, 1'b0);
		send_symbol(16'd9, 1'b0);
		send_symbol(16'd2, 1'b0);
		send_symbol(16'd2, 1'b1);
		send_symbol(16'd5, 1'b0);
		send_symbol(16'd5, 1'b1);
		drain();
	endtask

	// Flip the mode while a stream is open; the next pair follows the new mode
	task automatic test_mode_switch();
		set_delta_mode(1'b1);
		send_symbol(16'd100, 1'b0);
		send_symbol(16'd300, 1'b0);
		drain();
		set_delta_mode(1'b0);
		send_symbol(16'd50, 1'b0);
		send_symbol(16'd60, 1'b0);
		drain();
		set_delta_mode(1'b1);
		send_symbol(16'd60, 1'b0);
		send_symbol(16'd10, 1'b1);
		drain();
	endtask

	// Mostly well-formed streams over small alphabets, some pure noise,
	// some left open across a mode change
	task automatic test_random_streams(input int unsigned budget, input bit mode_changes);
		int unsigned      sent;
		int unsigned      len;
		bit               noisy;
		bit               closes;
		logic [SYM_W-1:0] alphabet[4];
		logic [SYM_W-1:0] cur;
		sent = 0;
		while (sent < budget) begin
			if (mode_changes && $urandom_range(0, 2) == 0) begin
				drain();
				set_delta_mode(1'($urandom_range(0, 1)));
			end
			len    = $urandom_range(1, 24);
			noisy  = ($urandom_range(0, 3) == 0);
			closes = ($urandom_range(0, 9) != 0);
			foreach (alphabet[k])
				alphabet[k] = $urandom_range(0, 3) == 0
					? SYM_MAX - SYM_W'($urandom_range(0, 3))
					: SYM_W'($urandom);
			cur = alphabet[0];
			for (int unsigned i = 0; i < len; i++) begin
				if (noisy)
					cur = SYM_W'($urandom);
				else if ($urandom_range(0, 1) == 0)
					cur = alphabet[$urandom_range(0, 3)];
				send_symbol(cur, closes && i == len - 1);
			end
			sent += len;
		end
		drain();
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		tracker_reset();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_on = 1'b1;
		test_raw_runs();
		test_delta_chain();
		test_mode_switch();
		test_random_streams(340, 1'b1);

		// Full rate from here on
		idle_on = 1'b0;
		set_delta_mode(1'b1);
		test_random_streams(60, 1'b0);

		$display("Sent %0d symbols, checked %0d run pairs (%0d delta coded, %0d negative)",
			symbols_sent, pairs_seen, delta_pairs, negative_deltas);
		$display("Count splits at saturation: %0d, mismatches: %0d", count_splits, mismatches);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Watchdog: the run needs well under 2 ms even at the slowest
	initial begin
		#20_000_000;
		$display("Timed out with %0d pairs still expected", pending_pairs.size());
		$display("FAILURE");
		$finish;
	end

endmodule
